/* hw/rtl/tangent_bitangent_accumulator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tangent / bitangent accumulator
// Shared property forms, used one per line in the accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef TANGENT_BITANGENT_ACCUMULATOR_MACROS_SVH
`define TANGENT_BITANGENT_ACCUMULATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define TBA_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tba_pkg.sv */
// ----------------------------------------------------------------------------
// tba_pkg
// Widths, command codes and divider interface types of the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package tba_pkg;

    localparam int IDX_W     = 10;
    localparam int COORD_W   = 32;
    localparam int ACC_W     = 48;
    localparam int OUT_W     = 16;
    localparam int S_TDATA_W = 200;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 112;

    localparam int DIV_NUM_W = 79;
    localparam int DIV_DEN_W = 64;
    localparam int DIV_STEPS = 79;

    localparam logic [ACC_W-1:0] ACC_LIM = 48'h7FFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TRI  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ACC_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/tangent_bitangent_accumulator.sv */
// ----------------------------------------------------------------------------
// tangent_bitangent_accumulator
// Per-vertex tangent space generation: loads vertices, accumulates triangle
// tangents and bitangents per corner, returns normalized sums in Q1.14.
//
//   Channel   Direction  Beat contents
//   s_        in         tuser: cmd; tdata: index, position, texcoord, corners
//   m_        out        tdata: vertex id, tangent xyz, bitangent xyz
//
// One item is in work at a time; s_tready is high only while idle.
// Load: vertex and accumulator memories written at acceptance.
// Triangle: six 79-step bit-serial divisions dominate.
// Read: normalizing shifts per vector, then the 32-step square root and
// six 79-step divisions.
// Reset clears control only; memory contents are undefined until loaded.
// A finished read waits in the output register while m_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tangent_bitangent_accumulator_macros.svh"

module tangent_bitangent_accumulator #(
    parameter int VERTEX_SLOTS = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [9:0] vertex_index, [41:10] pos_x, [73:42] pos_y, [105:74] pos_z,
    // [137:106] tex_u, [169:138] tex_v, [179:170] corner_a,
    // [189:180] corner_b, [199:190] corner_c
    input  wire logic [tba_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  wire logic [tba_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [9:0] vertex_id, [25:10] tangent_x, [41:26] tangent_y,
    // [57:42] tangent_z, [73:58] bitangent_x, [89:74] bitangent_y,
    // [105:90] bitangent_z, [111:106] zero
    output logic [tba_pkg::M_TDATA_W-1:0]      m_tdata
);
    import tba_pkg::*;

    localparam int ADDR_W = $clog2(VERTEX_SLOTS);
    localparam int VTX_W  = 5 * COORD_W;
    localparam int SUM_W  = 6 * ACC_W;

    localparam logic signed [ACC_W:0]   LIM49 = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [COORD_W:0] LIM33 = 33'sh0_7FFF_FFFF;

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_TRI_A   = 19'h00002,
        S_TRI_B   = 19'h00004,
        S_TRI_C   = 19'h00008,
        S_MUL0    = 19'h00010,
        S_MUL1    = 19'h00020,
        S_DIFF    = 19'h00040,
        S_DIV     = 19'h00080,
        S_ACC_RD  = 19'h00100,
        S_ACC_WR  = 19'h00200,
        S_RD_WAIT = 19'h00400,
        S_N_MAG   = 19'h00800,
        S_N_SHIFT = 19'h01000,
        S_N_SQ    = 19'h02000,
        S_N_SQE   = 19'h04000,
        S_N_SQRT  = 19'h08000,
        S_N_DIV0  = 19'h10000,
        S_N_DIV   = 19'h20000,
        S_OUT     = 19'h40000
    } state_t;

    function automatic logic slot_ok(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(VERTEX_SLOTS);
    endfunction

    function automatic logic signed [COORD_W-1:0] delta(
        input logic [COORD_W-1:0] b,
        input logic [COORD_W-1:0] a
    );
        logic signed [COORD_W:0] d;
        logic signed [COORD_W:0] nlim;
        d    = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
        nlim = -LIM33;
        if (d > LIM33) begin
            return LIM33[COORD_W-1:0];
        end else if (d < nlim) begin
            return nlim[COORD_W-1:0];
        end
        return d[COORD_W-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] sat_add(
        input logic [ACC_W-1:0] a,
        input logic [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        logic signed [ACC_W:0] nlim;
        s    = $signed({a[ACC_W-1], a}) + $signed({b[ACC_W-1], b});
        nlim = -LIM49;
        if (s > LIM49) begin
            return LIM49[ACC_W-1:0];
        end else if (s < nlim) begin
            return nlim[ACC_W-1:0];
        end
        return s[ACC_W-1:0];
    endfunction

    // Memories
    logic [VTX_W-1:0] vtx_mem_reg [VERTEX_SLOTS];
    logic [SUM_W-1:0] acc_mem_reg [VERTEX_SLOTS];
    logic [VTX_W-1:0] vq_reg;
    logic [SUM_W-1:0] aq_reg;

    state_t state_reg, state_next;

    logic             in_acc;
    cmd_t             in_cmd;
    logic [IDX_W-1:0] in_idx, in_ca, in_cb, in_cc;
    logic             tri_ok;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] corner_reg [3];
    logic             rd_oob_reg;

    logic [VTX_W-1:0]          va_reg;
    logic signed [COORD_W-1:0] e1_reg [3];
    logic signed [COORD_W-1:0] e2_reg [3];
    logic signed [COORD_W-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;

    logic         det_phase_reg;
    logic [2:0]   comp_reg;
    logic [1:0]   tri_i;
    logic signed [63:0] first_reg, prod_reg, det_reg;
    logic signed [63:0] diff;
    logic [63:0]  diff_mag, det_mag;
    logic         neg_reg;
    logic [ACC_W-1:0] tb_reg [6];
    logic [1:0]   k_reg;

    logic signed [COORD_W-1:0] mul_a, mul_b;
    logic signed [63:0]        mul_p;

    logic [ACC_W-1:0] vec_reg [6];
    logic             vsel_reg;
    logic [ACC_W-1:0] cur [3];
    logic [ACC_W-1:0] cur_mag [3];
    logic [ACC_W-1:0] cur_max;
    logic [ACC_W-1:0] mag_reg [3];
    logic             sgn_reg [3];
    logic [ACC_W-1:0] m_reg;
    logic [1:0]       j_reg;
    logic [63:0]      x_reg, res_reg, bit_reg;
    logic [63:0]      trial;
    logic [45:0]      norm_num;
    logic [2:0]       nidx;
    logic [OUT_W-1:0] nres_reg [6];

    logic [ADDR_W-1:0] vaddr, aaddr;
    logic              vtx_we, acc_we;
    logic [ADDR_W-1:0] acc_waddr;
    logic [SUM_W-1:0]  acc_wdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 out_load;

    // Input beat fields
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_cmd   = cmd_t'(s_tuser);
    assign in_idx   = s_tdata[9:0];
    assign in_ca    = s_tdata[179:170];
    assign in_cb    = s_tdata[189:180];
    assign in_cc    = s_tdata[199:190];
    assign tri_ok   = slot_ok(in_ca) && slot_ok(in_cb) && slot_ok(in_cc);

    // Memory address and write selection
    always_comb begin
        unique case (state_reg)
            S_TRI_A: vaddr = ADDR_W'(corner_reg[1]);
            S_TRI_B: vaddr = ADDR_W'(corner_reg[2]);
            default: vaddr = ADDR_W'(in_ca);
        endcase
        aaddr = (state_reg == S_IDLE) ? ADDR_W'(in_idx) : ADDR_W'(corner_reg[k_reg]);
        vtx_we = in_acc && (in_cmd == CMD_LOAD) && slot_ok(in_idx);
        acc_we = vtx_we || (state_reg == S_ACC_WR);
        acc_waddr = (state_reg == S_ACC_WR) ? ADDR_W'(corner_reg[k_reg]) : ADDR_W'(in_idx);
        acc_wdata = '0;
        if (state_reg == S_ACC_WR) begin
            for (int k = 0; k < 6; k++) begin
                acc_wdata[k*ACC_W +: ACC_W] = sat_add(aq_reg[k*ACC_W +: ACC_W], tb_reg[k]);
            end
        end
    end

    // Vertex and accumulator memories, registered read
    always_ff @(posedge aclk) begin
        if (vtx_we) begin
            vtx_mem_reg[ADDR_W'(in_idx)] <= s_tdata[169:10];
        end
        vq_reg <= vtx_mem_reg[vaddr];
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem_reg[acc_waddr] <= acc_wdata;
        end
        aq_reg <= acc_mem_reg[aaddr];
    end

    // Shared multiplier operands
    always_comb begin
        tri_i = (comp_reg < 3'd3) ? comp_reg[1:0] : 2'(comp_reg - 3'd3);
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_N_SQ) begin
            mul_a = {1'b0, mag_reg[j_reg][30:0]};
            mul_b = {1'b0, mag_reg[j_reg][30:0]};
        end else if (state_reg == S_MUL0) begin
            if (det_phase_reg) begin
                mul_a = du1_reg;
                mul_b = dv2_reg;
            end else if (comp_reg < 3'd3) begin
                mul_a = dv2_reg;
                mul_b = e1_reg[tri_i];
            end else begin
                mul_a = du1_reg;
                mul_b = e2_reg[tri_i];
            end
        end else begin
            if (det_phase_reg) begin
                mul_a = du2_reg;
                mul_b = dv1_reg;
            end else if (comp_reg < 3'd3) begin
                mul_a = dv1_reg;
                mul_b = e2_reg[tri_i];
            end else begin
                mul_a = du2_reg;
                mul_b = e1_reg[tri_i];
            end
        end
    end

    assign mul_p = mul_a * mul_b;

    // Difference of products, magnitudes for the divider
    always_comb begin
        diff     = first_reg - prod_reg;
        diff_mag = diff[63] ? 64'(-diff) : 64'(diff);
        det_mag  = det_reg[63] ? 64'(-det_reg) : 64'(det_reg);
    end

    // Normalization helpers
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cur[k]     = vsel_reg ? vec_reg[3+k] : vec_reg[k];
            cur_mag[k] = cur[k][ACC_W-1] ? ACC_W'(-cur[k]) : cur[k];
        end
        cur_max = cur_mag[0];
        if (cur_mag[1] > cur_max) begin
            cur_max = cur_mag[1];
        end
        if (cur_mag[2] > cur_max) begin
            cur_max = cur_mag[2];
        end
        trial    = res_reg + bit_reg;
        norm_num = {1'b0, mag_reg[j_reg][30:0], 14'b0} + 46'(res_reg >> 1);
        nidx     = (vsel_reg ? 3'd3 : 3'd0) + 3'(j_reg);
    end

    // Divider requests
    always_comb begin
        div_req.start = ((state_reg == S_DIFF) && !det_phase_reg) || (state_reg == S_N_DIV0);
        if (state_reg == S_N_DIV0) begin
            div_req.num = DIV_NUM_W'(norm_num);
            div_req.den = res_reg;
        end else begin
            div_req.num = {diff_mag[62:0], 16'b0};
            div_req.den = det_mag;
        end
    end

    tba_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_cmd)
                        CMD_TRI:  state_next = tri_ok ? S_TRI_A : S_IDLE;
                        CMD_READ: state_next = S_RD_WAIT;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_TRI_A:  state_next = S_TRI_B;
            S_TRI_B:  state_next = S_TRI_C;
            S_TRI_C:  state_next = S_MUL0;
            S_MUL0:   state_next = S_MUL1;
            S_MUL1:   state_next = S_DIFF;
            S_DIFF: begin
                if (!det_phase_reg) begin
                    state_next = S_DIV;
                end else if (diff == '0) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_MUL0;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = (comp_reg == 3'd5) ? S_ACC_RD : S_MUL0;
                end
            end
            S_ACC_RD: state_next = S_ACC_WR;
            S_ACC_WR: state_next = (k_reg == 2'd2) ? S_IDLE : S_ACC_RD;
            S_RD_WAIT: state_next = S_N_MAG;
            S_N_MAG: begin
                if (cur_max != '0) begin
                    state_next = S_N_SHIFT;
                end else if (vsel_reg) begin
                    state_next = S_OUT;
                end
            end
            S_N_SHIFT: begin
                if ((m_reg[ACC_W-1:31] == '0) && m_reg[30]) begin
                    state_next = S_N_SQ;
                end
            end
            S_N_SQ:   state_next = (j_reg == 2'd2) ? S_N_SQE : S_N_SQ;
            S_N_SQE:  state_next = S_N_SQRT;
            S_N_SQRT: state_next = (bit_reg == '0) ? S_N_DIV0 : S_N_SQRT;
            S_N_DIV0: state_next = S_N_DIV;
            S_N_DIV: begin
                if (div_rsp.done) begin
                    if (j_reg != 2'd2) begin
                        state_next = S_N_DIV0;
                    end else begin
                        state_next = vsel_reg ? S_OUT : S_N_MAG;
                    end
                end
            end
            S_OUT:   state_next = out_load ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        unique case (state_reg)
            S_IDLE: begin
                idx_reg       <= in_idx;
                corner_reg[0] <= in_ca;
                corner_reg[1] <= in_cb;
                corner_reg[2] <= in_cc;
                rd_oob_reg    <= !slot_ok(in_idx);
                det_phase_reg <= 1'b1;
                comp_reg      <= '0;
                k_reg         <= '0;
                vsel_reg      <= 1'b0;
            end
            S_TRI_A: begin
                va_reg <= vq_reg;
            end
            S_TRI_B: begin
                for (int k = 0; k < 3; k++) begin
                    e1_reg[k] <= delta(vq_reg[k*COORD_W +: COORD_W], va_reg[k*COORD_W +: COORD_W]);
                end
                du1_reg <= delta(vq_reg[3*COORD_W +: COORD_W], va_reg[3*COORD_W +: COORD_W]);
                dv1_reg <= delta(vq_reg[4*COORD_W +: COORD_W], va_reg[4*COORD_W +: COORD_W]);
            end
            S_TRI_C: begin
                for (int k = 0; k < 3; k++) begin
                    e2_reg[k] <= delta(vq_reg[k*COORD_W +: COORD_W], va_reg[k*COORD_W +: COORD_W]);
                end
                du2_reg <= delta(vq_reg[3*COORD_W +: COORD_W], va_reg[3*COORD_W +: COORD_W]);
                dv2_reg <= delta(vq_reg[4*COORD_W +: COORD_W], va_reg[4*COORD_W +: COORD_W]);
            end
            S_MUL1: begin
                first_reg <= prod_reg;
            end
            S_DIFF: begin
                if (det_phase_reg) begin
                    det_reg       <= diff;
                    det_phase_reg <= 1'b0;
                end else begin
                    neg_reg <= diff[63] ^ det_reg[63];
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    tb_reg[comp_reg] <= neg_reg ? ACC_W'(-div_rsp.quot) : div_rsp.quot;
                    comp_reg         <= comp_reg + 3'd1;
                end
            end
            S_ACC_WR: begin
                k_reg <= k_reg + 2'd1;
            end
            S_RD_WAIT: begin
                for (int k = 0; k < 6; k++) begin
                    vec_reg[k] <= rd_oob_reg ? '0 : aq_reg[k*ACC_W +: ACC_W];
                end
            end
            S_N_MAG: begin
                for (int k = 0; k < 3; k++) begin
                    mag_reg[k] <= cur_mag[k];
                    sgn_reg[k] <= cur[k][ACC_W-1];
                end
                m_reg <= cur_max;
                j_reg <= '0;
                x_reg <= '0;
                if (cur_max == '0) begin
                    // Zero vector reads as zero
                    for (int k = 0; k < 3; k++) begin
                        nres_reg[(vsel_reg ? 3 : 0) + k] <= '0;
                    end
                    vsel_reg <= 1'b1;
                end
            end
            S_N_SHIFT: begin
                if (m_reg[ACC_W-1:31] != '0) begin
                    m_reg <= m_reg >> 1;
                    for (int k = 0; k < 3; k++) begin
                        mag_reg[k] <= mag_reg[k] >> 1;
                    end
                end else if (!m_reg[30]) begin
                    m_reg <= m_reg << 1;
                    for (int k = 0; k < 3; k++) begin
                        mag_reg[k] <= mag_reg[k] << 1;
                    end
                end
            end
            S_N_SQ: begin
                if (j_reg != 2'd0) begin
                    x_reg <= x_reg + prod_reg;
                end
                j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
            end
            S_N_SQE: begin
                x_reg   <= x_reg + prod_reg;
                res_reg <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            S_N_SQRT: begin
                if (bit_reg != '0) begin
                    if (x_reg >= trial) begin
                        x_reg   <= x_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                j_reg <= '0;
            end
            S_N_DIV: begin
                if (div_rsp.done) begin
                    nres_reg[nidx] <= sgn_reg[j_reg] ? OUT_W'(-div_rsp.quot)
                                                     : OUT_W'(div_rsp.quot);
                    j_reg <= j_reg + 2'd1;
                    if (j_reg == 2'd2) begin
                        vsel_reg <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {6'b0, nres_reg[5], nres_reg[4], nres_reg[3],
                            nres_reg[2], nres_reg[1], nres_reg[0], idx_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `TBA_ASSERT_IMPLY(a_div_start_free, aclk, aresetn, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `TBA_ASSERT_NEXT(a_div_runs, aclk, aresetn, div_req.start, div_rsp.busy, "divider failed to start")
    `TBA_ASSERT_IMPLY(a_norm_bound, aclk, aresetn, (state_reg == S_N_DIV) && div_rsp.done, div_rsp.quot <= 48'd16384, "normalized magnitude above one")
    `TBA_ASSERT_IMPLY(a_shift_range, aclk, aresetn, state_reg == S_N_SQ, (m_reg[ACC_W-1:31] == '0) && m_reg[30], "scaled maximum out of range")

endmodule

`default_nettype wire

/* hw/rtl/tba_div.sv */
// ----------------------------------------------------------------------------
// tba_div
// Bit-serial restoring divider: one quotient bit per cycle, quotient
// magnitude saturated to ACC_LIM.
// ----------------------------------------------------------------------------
`default_nettype none

module tba_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tba_pkg::div_req_t req,
    output tba_pkg::div_rsp_t      rsp
);
    import tba_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [ACC_W-1:0]     quot_reg;
    logic                 sat_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic [DIV_DEN_W:0]   rem_shift;
    logic [DIV_DEN_W:0]   rem_diff;
    logic                 fits;
    logic [ACC_W-1:0]     quot_shift;

    // Trial subtract of the next partial remainder
    always_comb begin
        rem_shift  = {rem_reg, num_reg[DIV_NUM_W-1]};
        rem_diff   = rem_shift - {1'b0, den_reg};
        fits       = rem_shift >= {1'b0, den_reg};
        quot_shift = {quot_reg[ACC_W-2:0], fits};
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIV_STEPS);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift in dividend bits, develop quotient, freeze once saturated
    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg  <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
            quot_reg <= '0;
            sat_reg  <= 1'b0;
        end else if (run_reg) begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg <= fits ? rem_diff[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
            if (!sat_reg) begin
                if (quot_shift > ACC_LIM) begin
                    sat_reg <= 1'b1;
                end else begin
                    quot_reg <= quot_shift;
                end
            end
        end
    end

    assign rsp.busy = run_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = sat_reg ? ACC_LIM : quot_reg;

endmodule

`default_nettype wire
